// ===== hw/rtl/ilrs_pkg.sv =====
package ilrs_pkg;

    // Sizes of the design.
    localparam int SPAN_LIMIT    = 256;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int SPAN_W        = $clog2(SPAN_LIMIT + 1);

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 16;
    localparam int POS_W   = 16;
    localparam int SIZE_W  = 9;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 9;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PAL_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LINE_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL      = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_MAX_WIDTH   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_HEIGHT  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TRANSP_IDX  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_BG_IDX      = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_DISPOSAL    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_TRANSP_ON   = 3'd5;

    localparam logic [2:0]        DISPOSE_TO_BACKGROUND = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_DEFAULT          = 9'd240;
    localparam logic [SIZE_W-1:0] SIZE_MAX              = 9'd256;

    // Access request to the palette memory.
    typedef struct packed {
        logic               we;
        logic [PAL_AW-1:0]  waddr;
        logic [COLOR_W-1:0] wdata;
        logic               re;
        logic [PAL_AW-1:0]  raddr;
    } pal_req_t;

endpackage

// ===== hw/rtl/ilrs_palette.sv =====
module ilrs_palette
    import ilrs_pkg::*;
(
    input  logic               clk,
    input  pal_req_t           req,
    output logic [COLOR_W-1:0] rdata
);

    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    // The read register holds its value while no read is issued, so a
    // result waiting downstream keeps its colour.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            pal_mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= pal_mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/indexed_line_to_rgb565_spans_core.sv =====
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------
// input     | in_valid / in_stall       | cmd, index, color, line_x, line_y
// output    | out_valid / out_stall     | out_x, out_y, out_color, span_start
// config    | cfg_we                    | cfg_index, cfg_data
//
// One request is taken per clock while in_stall is low. A drawn pixel
// reaches the output through the registered palette read and then the
// output register.
// Reset clears the control state and the configuration to its defaults; the
// palette has no reset and must be written before it is read.
// A stalled output keeps its result, and the palette read stage behind it
// keeps one more, so input stalls only when both are full.
module indexed_line_to_rgb565_spans_core
    import ilrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [IDX_W-1:0]   index,
    input  logic [COLOR_W-1:0] color,
    input  logic [POS_W-1:0]   line_x,
    input  logic [POS_W-1:0]   line_y,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_x,
    output logic [7:0]         out_y,
    output logic [COLOR_W-1:0] out_color,
    output logic               span_start,

    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_index,
    input  logic [CFG_DW-1:0]  cfg_data
);

    // An out-of-range display size falls back to the default.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0 || v > SIZE_MAX)
            r = SIZE_DEFAULT;
        else
            r = v;
        return r;
    endfunction

    // Configuration registers.
    logic [SIZE_W-1:0] max_width_reg;
    logic [SIZE_W-1:0] max_height_reg;
    logic [IDX_W-1:0]  transp_idx_reg;
    logic [IDX_W-1:0]  bg_idx_reg;
    logic [2:0]        disposal_reg;
    logic              transp_on_reg;

    // Line state.
    logic [POS_W-1:0]  column_reg, column_next;
    logic [POS_W-1:0]  origin_x_reg;
    logic [POS_W-1:0]  row_reg;
    logic              line_active_reg;
    logic [SPAN_W-1:0] span_count_reg, span_count_next;

    // Palette read stage and output register.
    logic              s1_valid_reg;
    logic [7:0]        s1_x_reg;
    logic [7:0]        s1_y_reg;
    logic              s1_start_reg;
    logic              s1_oob_reg;
    logic              out_valid_reg;
    logic [7:0]        out_x_reg;
    logic [7:0]        out_y_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic              out_start_reg;

    logic               in_accept;
    logic               s1_move;
    logic               is_pixel;
    logic [POS_W:0]     x_sum;
    logic               cropped;
    logic               dispose_bg;
    logic [IDX_W-1:0]   eff_idx;
    logic               skip;
    logic               emit;
    logic               start;
    logic               oob;
    logic [COLOR_W-1:0] pal_rdata;
    pal_req_t           pal_req;

    // The read stage drains into the output register whenever that register
    // is empty or its result is being taken this cycle.
    assign s1_move   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        is_pixel   = in_accept && (cmd == CMD_PIXEL) && line_active_reg;
        x_sum      = {1'b0, origin_x_reg} + {1'b0, column_reg};
        cropped    = (row_reg >= POS_W'(max_height_reg))
                     || (x_sum >= (POS_W + 1)'(max_width_reg));
        dispose_bg = (disposal_reg == DISPOSE_TO_BACKGROUND);
        // Under restore-to-background the transparent index is painted with
        // the background index instead of being skipped.
        eff_idx    = (dispose_bg && index == transp_idx_reg) ? bg_idx_reg : index;
        skip       = !dispose_bg && transp_on_reg && (index == transp_idx_reg);
        emit       = is_pixel && !cropped && !skip;
        start      = (span_count_reg == '0) || (span_count_reg >= SPAN_W'(SPAN_LIMIT));
        oob        = ({1'b0, eff_idx} >= (IDX_W + 1)'(PALETTE_DEPTH));

        column_next = column_reg;
        if (is_pixel && column_reg != '1)
            column_next = column_reg + POS_W'(1);

        span_count_next = span_count_reg;
        if (is_pixel && !cropped)
        begin
            if (skip)
                span_count_next = '0;
            else if (start)
                span_count_next = SPAN_W'(1);
            else
                span_count_next = span_count_reg + SPAN_W'(1);
        end

        pal_req.we    = in_accept && (cmd == CMD_PAL_WRITE)
                        && ({1'b0, index} < (IDX_W + 1)'(PALETTE_DEPTH));
        pal_req.waddr = index[PAL_AW-1:0];
        pal_req.wdata = color;
        pal_req.re    = emit;
        pal_req.raddr = eff_idx[PAL_AW-1:0];
    end

    // A palette write and a later pixel are never accepted at the same edge,
    // so the read always sees every write accepted before it.
    ilrs_palette u_palette
    (
        .clk   (clk),
        .req   (pal_req),
        .rdata (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg  <= SIZE_DEFAULT;
            max_height_reg <= SIZE_DEFAULT;
            transp_idx_reg <= '0;
            bg_idx_reg     <= '0;
            disposal_reg   <= '0;
            transp_on_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_WIDTH:  max_width_reg  <= clamp_size(cfg_data);
                CFG_MAX_HEIGHT: max_height_reg <= clamp_size(cfg_data);
                CFG_TRANSP_IDX: transp_idx_reg <= cfg_data[IDX_W-1:0];
                CFG_BG_IDX:     bg_idx_reg     <= cfg_data[IDX_W-1:0];
                CFG_DISPOSAL:   disposal_reg   <= cfg_data[2:0];
                CFG_TRANSP_ON:  transp_on_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Line state: a line start resets the column and the span counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg      <= '0;
            origin_x_reg    <= '0;
            row_reg         <= '0;
            line_active_reg <= 1'b0;
            span_count_reg  <= '0;
        end
        else if (in_accept && cmd == CMD_LINE_START)
        begin
            column_reg      <= '0;
            origin_x_reg    <= line_x;
            row_reg         <= line_y;
            line_active_reg <= 1'b1;
            span_count_reg  <= '0;
        end
        else
        begin
            column_reg     <= column_next;
            span_count_reg <= span_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_x_reg     <= x_sum[7:0];
            s1_y_reg     <= row_reg[7:0];
            s1_start_reg <= start;
            s1_oob_reg   <= oob;
        end
        if (s1_move)
        begin
            out_x_reg     <= s1_x_reg;
            out_y_reg     <= s1_y_reg;
            out_start_reg <= s1_start_reg;
            out_color_reg <= s1_oob_reg ? '0 : pal_rdata;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_color  = out_color_reg;
    assign span_start = out_start_reg;

endmodule

// ===== hw/rtl/ilrs_checker.sv =====
module ilrs_checker
    import ilrs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [7:0]         out_x,
    input  logic [7:0]         out_y,
    input  logic [COLOR_W-1:0] out_color,
    input  logic               span_start
);

    // Input backs up only behind a full, stalled output.
    assert property (@(posedge clk) in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output can drain");

    // A result on an empty output follows an accepted pixel through the read stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && cmd == CMD_PIXEL, 2))
        else $error("result without a preceding pixel");

    // Reset leaves the output empty.
    assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_color) && $stable(span_start)))
        else $error("stalled result changed");

endmodule

bind indexed_line_to_rgb565_spans_core ilrs_checker u_ilrs_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_color  (out_color),
    .span_start (span_start)
);

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ilrs_pkg::*;

    // The fourth command code has no meaning for the block; it is sent as noise.
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int N_PHASES     = 8;
    // Requests the block acts on over the whole run, directed ones included.
    localparam int ITEM_BUDGET  = 1450;
    // The two-stage pipeline holds only drawn pixels; settings still wait this
    // long after the last drawn pixel has been checked.
    localparam int IDLE_PAUSE   = 6;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   line_x;
        logic [POS_W-1:0]   line_y;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0]         x;
        logic [7:0]         y;
        logic [COLOR_W-1:0] color;
        logic               start;
    } drawn_pixel_t;

    // The scoreboard mirrors the block: the palette, the display settings and
    // the line and span state. Each accepted request updates that state, and a
    // drawn pixel is queued until the block presents it.
    class span_scoreboard;
        logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
        int unsigned        width_lim;
        int unsigned        height_lim;
        logic [IDX_W-1:0]   transp_idx;
        logic [IDX_W-1:0]   bg_idx;
        logic [2:0]         disposal;
        logic               transp_on;
        int unsigned        column;
        int unsigned        origin;
        int unsigned        line_row;
        int unsigned        run_len;
        bit                 line_active;
        drawn_pixel_t       drawn_q [$];
        int                 errors;

        function new();
            width_lim   = SIZE_DEFAULT;
            height_lim  = SIZE_DEFAULT;
            transp_idx  = '0;
            bg_idx      = '0;
            disposal    = '0;
            transp_on   = 1'b0;
            column      = 0;
            origin      = 0;
            line_row    = 0;
            run_len     = 0;
            line_active = 1'b0;
            errors      = 0;
            foreach (palette[i])
                palette[i] = '0;
        endfunction

        // A display size of zero or beyond the largest screen falls back to the default.
        function int unsigned legal_size(logic [CFG_DW-1:0] v);
            return (v == 0 || v > SIZE_MAX) ? SIZE_DEFAULT : v;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_MAX_WIDTH:  width_lim  = legal_size(data);
                CFG_MAX_HEIGHT: height_lim = legal_size(data);
                CFG_TRANSP_IDX: transp_idx = data[IDX_W-1:0];
                CFG_BG_IDX:     bg_idx     = data[IDX_W-1:0];
                CFG_DISPOSAL:   disposal   = data[2:0];
                CFG_TRANSP_ON:  transp_on  = data[0];
                default: ;
            endcase
        endfunction

        function void note_request(pixel_req_t r);
            int unsigned      x;
            logic [IDX_W-1:0] pick;
            bit               skip;
            bit               first;
            drawn_pixel_t     d;
            case (r.cmd)
                CMD_PAL_WRITE:
                    palette[r.index] = r.color;
                CMD_LINE_START:
                begin
                    origin      = r.line_x;
                    line_row    = r.line_y;
                    column      = 0;
                    run_len     = 0;
                    line_active = 1'b1;
                end
                CMD_PIXEL:
                begin
                    if (line_active)
                    begin
                        x = origin + column;
                        if (column < 16'hFFFF)
                            column++;
                        if (line_row < height_lim && x < width_lim)
                        begin
                            pick = r.index;
                            skip = transp_on;
                            if (disposal == DISPOSE_TO_BACKGROUND)
                            begin
                                if (pick == transp_idx)
                                    pick = bg_idx;
                                skip = 1'b0;
                            end
                            if (skip && pick == transp_idx)
                                run_len = 0;
                            else
                            begin
                                first   = (run_len == 0) || (run_len >= SPAN_LIMIT);
                                run_len = first ? 1 : run_len + 1;
                                d.x     = x[7:0];
                                d.y     = line_row[7:0];
                                d.color = palette[pick];
                                d.start = first;
                                drawn_q.push_back(d);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(drawn_pixel_t got);
            drawn_pixel_t want;
            if (drawn_q.size() == 0)
            begin
                $error("unexpected pixel: x=%0d y=%0d color=%h span_start=%0b",
                       got.x, got.y, got.color, got.start);
                errors++;
                return;
            end
            want = drawn_q.pop_front();
            if (got.x !== want.x)
            begin
                $error("out_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y)
            begin
                $error("out_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.color !== want.color)
            begin
                $error("out_color: expected %h, got %h", want.color, got.color);
                errors++;
            end
            if (got.start !== want.start)
            begin
                $error("span_start: expected %0b, got %0b", want.start, got.start);
                errors++;
            end
        endfunction

        function int pending();
            return drawn_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd = '0;
    logic [IDX_W-1:0]   index = '0;
    logic [COLOR_W-1:0] color = '0;
    logic [POS_W-1:0]   line_x = '0;
    logic [POS_W-1:0]   line_y = '0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         out_x;
    logic [7:0]         out_y;
    logic [COLOR_W-1:0] out_color;
    logic               span_start;

    logic               cfg_we = 1'b0;
    logic [CFG_AW-1:0]  cfg_index = '0;
    logic [CFG_DW-1:0]  cfg_data = '0;

    span_scoreboard     sb = new();

    // Requests that the block acts on; ignored ones do not count toward the budget.
    int unsigned        accepted = 0;
    int unsigned        cycle_count = 0;
    // When set, the sender keeps its requests back to back.
    bit                 steady = 1'b0;

    indexed_line_to_rgb565_spans_core DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is cut off if it hangs, for example when a pixel never comes out.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Every pixel taken from the output channel is checked against the oldest
    // expected one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({out_x, out_y, out_color, span_start});
    end

    // Mostly short idle gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // The output side stalls in bursts. Runs without any stall, mostly short and
    // now and then long, alternate with short and occasional long stalls, so that
    // both pipeline stages fill and the input stall is exercised too.
    initial
    begin
        int unsigned run;
        int unsigned hold;
        wait (rst_n === 1'b1);
        forever
        begin
            run  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(1, 8);
            hold = pick_gap();
            if (hold == 0)
                hold = $urandom_range(1, 2);
            repeat (run) @(negedge clk);
            out_stall <= 1'b1;
            repeat (hold) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    function automatic pixel_req_t make_req(logic [CMD_W-1:0] c, logic [IDX_W-1:0] i,
                                            logic [COLOR_W-1:0] col,
                                            logic [POS_W-1:0] lx, logic [POS_W-1:0] ly);
        pixel_req_t r;
        r.cmd    = c;
        r.index  = i;
        r.color  = col;
        r.line_x = lx;
        r.line_y = ly;
        return r;
    endfunction

    // Fields that a command does not use still carry random values.
    function automatic pixel_req_t random_req(logic [CMD_W-1:0] c);
        return make_req(c, IDX_W'($urandom_range(0, 255)),
                        COLOR_W'($urandom_range(0, 65535)),
                        POS_W'($urandom_range(0, 65535)),
                        POS_W'($urandom_range(0, 65535)));
    endfunction

    // Called at a falling edge and returns at one. Valid stays high after the
    // request is taken, so a following request without a gap simply replaces
    // the payload at the next falling edge.
    task automatic send(input pixel_req_t r);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= r.cmd;
        index    <= r.index;
        color    <= r.color;
        line_x   <= r.line_x;
        line_y   <= r.line_y;
        do
            @(posedge clk);
        while (in_stall);
        if (r.cmd != CMD_NONE && (r.cmd != CMD_PIXEL || sb.line_active))
            accepted++;
        sb.note_request(r);
        @(negedge clk);
    endtask

    // Settings change only while the block is idle: every drawn pixel has been
    // checked and the pipeline has had time to empty.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (IDLE_PAUSE) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic write_settings(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                                  input logic [CFG_DW-1:0] t, input logic [CFG_DW-1:0] b,
                                  input logic [CFG_DW-1:0] d, input logic [CFG_DW-1:0] on);
        put_reg(CFG_MAX_WIDTH, w);
        put_reg(CFG_MAX_HEIGHT, h);
        put_reg(CFG_TRANSP_IDX, t);
        put_reg(CFG_BG_IDX, b);
        put_reg(CFG_DISPOSAL, d);
        put_reg(CFG_TRANSP_ON, on);
        cfg_we <= 1'b0;
    endtask

    // Display sizes include out-of-range values, which must fall back to the default.
    function automatic logic [CFG_DW-1:0] random_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 14)
            return CFG_DW'($urandom_range(257, 511));
        if (roll < 30)
            return SIZE_MAX;
        if (roll < 38)
            return 1;
        return CFG_DW'($urandom_range(2, 255));
    endfunction

    // The narrow registers get random upper bits, which the block must ignore.
    task automatic configure(input int phase);
        logic [CFG_DW-1:0] disp;
        case (phase)
            1: write_settings(SIZE_MAX, SIZE_MAX, 255, 0, 0, 1);
            2: write_settings(1, 1, 0, 255, DISPOSE_TO_BACKGROUND, 1);
            3: write_settings(0, 511, 9'h1AA, 9'h155, 9'h1FF, 9'h1FE);
            default:
            begin
                disp = CFG_DW'($urandom_range(0, 511));
                if ($urandom_range(0, 2) == 0)
                    disp[2:0] = DISPOSE_TO_BACKGROUND;
                write_settings(random_size(), random_size(),
                               CFG_DW'($urandom_range(0, 511)),
                               CFG_DW'($urandom_range(0, 511)), disp,
                               CFG_DW'($urandom_range(0, 511)));
            end
        endcase
    endtask

    // Short hand-picked sequences at the start of the first phases.
    task automatic directed(input int phase);
        case (phase)
            0:
            begin
                // The whole palette is loaded first, so no pixel ever reads an
                // entry that was never written.
                for (int i = 0; i < PALETTE_DEPTH; i++)
                    send(make_req(CMD_PAL_WRITE, IDX_W'(i),
                                  COLOR_W'($urandom_range(0, 65535)), 0, 0));
                // A pixel before any line start and the unused command are ignored.
                send(make_req(CMD_PIXEL, 8'h5A, 0, 0, 0));
                send(make_req(CMD_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
                send(make_req(CMD_LINE_START, 0, 0, 0, 0));
                send(make_req(CMD_PIXEL, 8'h00, 0, 0, 0));
                send(make_req(CMD_PIXEL, 8'hFF, 0, 0, 0));
                send(make_req(CMD_NONE, 0, 0, 0, 0));
                // Palette updates in the middle of a line take effect at once.
                send(make_req(CMD_PAL_WRITE, 8'hA5, 16'hFFFF, 0, 0));
                send(make_req(CMD_PIXEL, 8'hA5, 0, 0, 0));
                send(make_req(CMD_PAL_WRITE, 8'h5A, 16'h0000, 0, 0));
                send(make_req(CMD_PIXEL, 8'h5A, 0, 0, 0));
                // The last row, and the third pixel falls off the right edge.
                send(make_req(CMD_LINE_START, 0, 0, 238, 239));
                send(random_req(CMD_PIXEL));
                send(random_req(CMD_PIXEL));
                send(random_req(CMD_PIXEL));
                // Far off screen in both directions.
                send(make_req(CMD_LINE_START, 0, 0, 16'hFFFF, 16'hFFFF));
                send(random_req(CMD_PIXEL));
                // First row below the display.
                send(make_req(CMD_LINE_START, 0, 0, 0, 240));
                send(random_req(CMD_PIXEL));
            end
            1:
            begin
                // A transparent pixel is skipped and the next one opens a new span.
                send(make_req(CMD_LINE_START, 0, 0, 0, 1));
                send(make_req(CMD_PIXEL, 1, 0, 0, 0));
                send(make_req(CMD_PIXEL, 255, 0, 0, 0));
                send(make_req(CMD_PIXEL, 2, 0, 0, 0));
            end
            2:
            begin
                // Restore to background: the transparent index draws the background colour.
                send(make_req(CMD_LINE_START, 0, 0, 0, 0));
                send(make_req(CMD_PIXEL, 0, 0, 0, 0));
                send(make_req(CMD_PIXEL, 0, 0, 0, 0));
            end
            default: ;
        endcase
    endtask

    function automatic logic [POS_W-1:0] pick_origin();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return POS_W'($urandom_range(0, sb.width_lim));
        if (roll < 85)
            return POS_W'($urandom_range(0, 300));
        return POS_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [POS_W-1:0] pick_row();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return POS_W'($urandom_range(0, sb.height_lim - 1));
        if (roll < 88)
            return POS_W'($urandom_range(sb.height_lim, sb.height_lim + 4));
        return POS_W'($urandom_range(0, 65535));
    endfunction

    // One line: a line start and a run of pixels with the odd palette write
    // or unused command mixed in. Pixels often hit the transparent and the
    // background index. A rare solid line runs across the whole display
    // without transparent pixels to build the longest spans.
    task automatic random_line();
        pixel_req_t  r;
        int unsigned n;
        int unsigned roll;
        bit          solid;
        solid = ($urandom_range(0, 39) == 0);
        if (solid)
            n = $urandom_range(250, 300);
        else if ($urandom_range(0, 9) < 8)
            n = $urandom_range(1, 24);
        else
            n = $urandom_range(25, 80);
        r = random_req(CMD_LINE_START);
        r.line_x = solid ? POS_W'($urandom_range(0, 3)) : pick_origin();
        r.line_y = pick_row();
        send(r);
        for (int k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                r = random_req(CMD_PAL_WRITE);
            else if (roll < 7)
                r = random_req(CMD_NONE);
            else
            begin
                r = random_req(CMD_PIXEL);
                if (solid)
                begin
                    if (r.index == sb.transp_idx)
                        r.index = r.index + IDX_W'(1);
                end
                else if (roll < 30)
                    r.index = sb.transp_idx;
                else if (roll < 35)
                    r.index = sb.bg_idx;
            end
            send(r);
        end
    endtask

    // The run: reset, then phases of settings, each with its directed requests
    // and random lines up to its share of the whole budget. Every third phase
    // sends back to back.
    initial
    begin
        int unsigned quota;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int p = 0; p < N_PHASES; p++)
        begin
            steady = (p % 3 == 2);
            if (p > 0)
            begin
                wait_idle();
                configure(p);
            end
            directed(p);
            quota = (p + 1) * ITEM_BUDGET / N_PHASES;
            while (accepted < quota)
                random_line();
        end
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
